// ===== hw/rtl/pcr_pkg.sv =====
// Shared constants for the particle contact resolver: field widths,
// stream packing offsets and fixed-point format constants.
// No dependencies; imported by every other file of the project.
`default_nettype none

package pcr_pkg;

  // Packed vector and scalar field widths
  localparam int VEC_W     = 63;
  localparam int NORM_BITS = 21;
  localparam int NORM_FRAC = 19;
  localparam int MASS_W    = 24;
  localparam int REST_W    = 17;
  localparam int REST_FRAC = 16;
  localparam int PEN_W     = 21;
  localparam int HTS_W     = 24;

  // Split point for wide products, equal to the Q0.24 fraction of the timestep term
  localparam int SPLIT = 24;

  localparam logic [HTS_W-1:0] HTS_RESET = 24'd2330;

  // Input stream layout (s_tdata)
  localparam int V1_LSB    = 0;
  localparam int V2_LSB    = 63;
  localparam int A1_LSB    = 126;
  localparam int A2_LSB    = 189;
  localparam int X1_LSB    = 252;
  localparam int X2_LSB    = 315;
  localparam int N_LSB     = 378;
  localparam int IM1_LSB   = 441;
  localparam int IM2_LSB   = 465;
  localparam int REST_LSB  = 489;
  localparam int PEN_LSB   = 506;
  localparam int S_TDATA_W = 528;

  // Output stream layout (m_tdata)
  localparam int OV1_LSB   = 0;
  localparam int OV2_LSB   = 63;
  localparam int OX1_LSB   = 126;
  localparam int OX2_LSB   = 189;
  localparam int M_TDATA_W = 256;

endpackage

`default_nettype wire

// ===== hw/rtl/pcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Divides a product of a QW-bit value and an inverse mass by the total inverse mass.
// Depends on pcr_pkg.
`default_nettype none

module pcr_div
  import pcr_pkg::*;
#(
  parameter int QW = 28
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [QW+MASS_W-1:0]   num,
  input  logic [MASS_W:0]        den,
  output logic [QW-1:0]          quo
);

  localparam int DEN_W = MASS_W + 1;

  // Per-stage partial remainder, divisor, and numerator/quotient shift word
  logic [DEN_W-1:0] rem_q [QW-1];
  logic [DEN_W-1:0] den_q [QW-1];
  logic [QW-1:0]    x_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [DEN_W-1:0] d_in;
    logic [QW-1:0]    x_in;
    logic [DEN_W:0]   t;
    logic             ge;

    // The quotient fits QW bits, so the top numerator bits start below the divisor
    if (k == 0) begin : g_first
      assign r_in = {1'b0, num[QW +: MASS_W]};
      assign x_in = num[QW-1:0];
      assign d_in = den;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign x_in = x_q[k-1];
      assign d_in = den_q[k-1];
    end

    // Shift in the next numerator bit and try one subtraction
    assign t  = {r_in, x_in[QW-1]};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[k] <= {x_in[QW-2:0], ge};
      end
    end

    // Carry remainder and divisor to the next stage
    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? DEN_W'(t - {1'b0, d_in}) : t[DEN_W-1:0];
          den_q[k] <= d_in;
        end
      end
    end
  end

  assign quo = x_q[QW-1];

endmodule

`default_nettype wire

// ===== hw/rtl/particle_contact_resolver.sv =====
// Particle contact resolver top level: impulse and interpenetration
// correction for one two-particle contact per request. Depends on pcr_pkg, pcr_div.
`default_nettype none

// Usage
//   Input channel s_*: one contact per request, accepted when s_tvalid and
//   s_tready are high. has_second travels in s_tuser.
//   Output channel m_*: one resolved contact per request; impulse_applied
//   and position_corrected travel in m_tuser.
//   cfg_wr_en/cfg_wr_data write half_timestep_sq; write only while idle.
// Pipeline: a divider shares each speed and depth change by inverse mass,
//   one quotient bit per stage, with QW = max(COMPONENT_BITS+7, 20) quotient
//   bits. Ten more stages hold the dot products, split wide multiplies
//   and the final update with saturation.
// Throughput: one request per cycle unless stalled. All stages advance together.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready is low; nothing is dropped or repeated. Bubbles advance.
// Reset: rst (synchronous, active high) clears all valid bits and loads
//   half_timestep_sq with 2330. Payload registers are not reset.
module particle_contact_resolver
  import pcr_pkg::*;
#(
  parameter int COMPONENT_BITS = 21
) (
  input  logic                 clk,
  input  logic                 rst,
  // half_timestep_sq write
  input  logic                 cfg_wr_en,
  input  logic [HTS_W-1:0]     cfg_wr_data,
  // p1_velocity, p2_velocity, p1_acceleration, p2_acceleration, p1_position,
  // p2_position, contact_normal, p1_inv_mass, p2_inv_mass, restitution, penetration
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,    // has_second
  // p1_new_velocity, p2_new_velocity, p1_new_position, p2_new_position
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [1:0]           m_tuser     // impulse_applied, position_corrected
);

  localparam int C      = COMPONENT_BITS;
  localparam int C3     = 3 * C;
  localparam int DIFF_W = C + 1;
  localparam int DOT_W  = DIFF_W + NORM_BITS;
  localparam int S_W    = C + 24;
  localparam int PLO_W  = SPLIT + HTS_W;
  localparam int P_W    = S_W + 1;
  localparam int SUM_W  = S_W + 2;
  localparam int RLO_W  = SPLIT + REST_W;
  localparam int RP_W   = (SUM_W - SPLIT) + REST_W + 1;
  localparam int TGT_W  = C + 29;
  localparam int DV_W   = C + 7;
  localparam int QW     = (DV_W > PEN_W - 1) ? DV_W : PEN_W - 1;
  localparam int NUM_W  = QW + MASS_W;
  localparam int WP_W   = QW + 1 + NORM_BITS;
  localparam int R_W    = QW + 4;
  localparam int LAT    = QW + 10;

  localparam logic signed [R_W-1:0] MAX_C = R_W'((2 ** (C - 1)) - 1);
  localparam logic signed [R_W-1:0] MIN_C = -MAX_C - R_W'(1);

  typedef struct packed {
    logic [C3-1:0]              v1;
    logic [C3-1:0]              v2;
    logic [C3-1:0]              x1;
    logic [C3-1:0]              x2;
    logic [3*NORM_BITS-1:0]     n;
    logic                       two;
    logic                       pos;
    logic                       imp;
    logic [PEN_W-2:0]           pen_use;
    logic [MASS_W-1:0]          im1;
    logic [MASS_W-1:0]          im2;
    logic [MASS_W:0]            total;
    logic [REST_W-1:0]          rest;
    logic signed [S_W-1:0]      sep;
  } ctx_t;

  // Control and configuration
  logic [HTS_W-1:0] hts;
  logic [LAT-1:0]   vld;
  logic             adv;

  assign adv      = !vld[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      hts <= HTS_RESET;
    end else if (cfg_wr_en) begin
      hts <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Stage 1: unpack, relative velocity and acceleration times normal
  ctx_t                        in_c;
  logic signed [PEN_W-1:0]     pen_in;
  logic signed [C-1:0]         v1c [3];
  logic signed [C-1:0]         v2c [3];
  logic signed [C-1:0]         a1c [3];
  logic signed [C-1:0]         a2c [3];
  logic signed [NORM_BITS-1:0] nc  [3];
  logic signed [DIFF_W-1:0]    dvel [3];
  logic signed [DIFF_W-1:0]    dacc [3];
  logic signed [DOT_W-1:0]     pv_d [3];
  logic signed [DOT_W-1:0]     pa_d [3];
  logic signed [DOT_W-1:0]     pv_q [3];
  logic signed [DOT_W-1:0]     pa_q [3];
  ctx_t                        c1;

  always_comb begin
    in_c.v1      = s_tdata[V1_LSB +: C3];
    in_c.v2      = s_tdata[V2_LSB +: C3];
    in_c.x1      = s_tdata[X1_LSB +: C3];
    in_c.x2      = s_tdata[X2_LSB +: C3];
    in_c.n       = s_tdata[N_LSB +: 3*NORM_BITS];
    in_c.two     = s_tuser;
    in_c.im1     = s_tdata[IM1_LSB +: MASS_W];
    in_c.im2     = s_tuser ? s_tdata[IM2_LSB +: MASS_W] : '0;
    in_c.total   = {1'b0, in_c.im1} + {1'b0, in_c.im2};
    in_c.rest    = s_tdata[REST_LSB +: REST_W];
    pen_in       = $signed(s_tdata[PEN_LSB +: PEN_W]);
    in_c.pos     = !pen_in[PEN_W-1] && (in_c.total != '0);
    in_c.pen_use = pen_in[PEN_W-1] ? '0 : pen_in[PEN_W-2:0];
    in_c.imp     = 1'b0;
    in_c.sep     = '0;
    for (int i = 0; i < 3; i++) begin
      v1c[i]  = $signed(s_tdata[V1_LSB + i*C +: C]);
      v2c[i]  = $signed(s_tdata[V2_LSB + i*C +: C]);
      a1c[i]  = $signed(s_tdata[A1_LSB + i*C +: C]);
      a2c[i]  = $signed(s_tdata[A2_LSB + i*C +: C]);
      nc[i]   = $signed(s_tdata[N_LSB + i*NORM_BITS +: NORM_BITS]);
      dvel[i] = DIFF_W'(v1c[i]) - (s_tuser ? DIFF_W'(v2c[i]) : DIFF_W'(0));
      dacc[i] = DIFF_W'(a1c[i]) - (s_tuser ? DIFF_W'(a2c[i]) : DIFF_W'(0));
      pv_d[i] = dvel[i] * nc[i];
      pa_d[i] = dacc[i] * nc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= in_c;
      for (int i = 0; i < 3; i++) begin
        pv_q[i] <= pv_d[i];
        pa_q[i] <= pa_d[i];
      end
    end
  end

  // Stage 2: sum the dot products, decide on the impulse
  logic signed [S_W-1:0] sep_d;
  logic signed [S_W-1:0] adot_d;
  logic signed [S_W-1:0] adot_q;
  ctx_t                  c2_d;
  ctx_t                  c2;

  assign sep_d  = S_W'(pv_q[0]) + S_W'(pv_q[1]) + S_W'(pv_q[2]);
  assign adot_d = S_W'(pa_q[0]) + S_W'(pa_q[1]) + S_W'(pa_q[2]);

  always_comb begin
    c2_d     = c1;
    c2_d.sep = sep_d;
    c2_d.imp = (sep_d <= 0) && (c1.total != '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2     <= c2_d;
      adot_q <= adot_d;
    end
  end

  // Stage 3: acceleration term times half timestep squared, in two halves
  logic [PLO_W-1:0]      plo_d;
  logic signed [P_W-1:0] phi_d;
  logic [PLO_W-1:0]      plo_q;
  logic signed [P_W-1:0] phi_q;
  ctx_t                  c3;

  assign plo_d = adot_q[SPLIT-1:0] * hts;
  assign phi_d = $signed(adot_q[S_W-1:SPLIT]) * $signed({1'b0, hts});

  always_ff @(posedge clk) begin
    if (adv) begin
      c3    <= c2;
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  // Stage 4: floor of the scaled term, keep only negative, subtract separation
  logic signed [P_W-1:0]   acc;
  logic signed [P_W-1:0]   acc_min;
  logic signed [SUM_W-1:0] sum_d;
  logic signed [SUM_W-1:0] sum_q;
  ctx_t                    c4;

  assign acc     = phi_q + $signed({{(P_W-(PLO_W-SPLIT)){1'b0}}, plo_q[PLO_W-1:SPLIT]});
  assign acc_min = acc[P_W-1] ? acc : '0;
  assign sum_d   = SUM_W'(acc_min) - SUM_W'(c3.sep);

  always_ff @(posedge clk) begin
    if (adv) begin
      c4    <= c3;
      sum_q <= sum_d;
    end
  end

  // Stage 5: restitution times the speed, in two halves
  logic [RLO_W-1:0]       rlo_d;
  logic signed [RP_W-1:0] rhi_d;
  logic [RLO_W-1:0]       rlo_q;
  logic signed [RP_W-1:0] rhi_q;
  ctx_t                   c5;

  assign rlo_d = sum_q[SPLIT-1:0] * c4.rest;
  assign rhi_d = $signed(sum_q[SUM_W-1:SPLIT]) * $signed({1'b0, c4.rest});

  always_ff @(posedge clk) begin
    if (adv) begin
      c5    <= c4;
      rlo_q <= rlo_d;
      rhi_q <= rhi_d;
    end
  end

  // Stage 6: recombine into the target separating speed
  logic signed [TGT_W-1:0] tgt_d;
  logic signed [TGT_W-1:0] tgt_q;
  ctx_t                    c6;

  assign tgt_d = (TGT_W'(rhi_q) <<< (SPLIT - REST_FRAC))
               + $signed({{(TGT_W-(RLO_W-REST_FRAC)){1'b0}}, rlo_q[RLO_W-1:REST_FRAC]});

  always_ff @(posedge clk) begin
    if (adv) begin
      c6    <= c5;
      tgt_q <= tgt_d;
    end
  end

  // Stage 7: clamp at zero, speed change in velocity units
  logic signed [TGT_W-1:0] tgt_c;
  logic signed [TGT_W:0]   diff_d;
  logic [QW-1:0]           dv_q;
  ctx_t                    c7;

  assign tgt_c  = tgt_q[TGT_W-1] ? '0 : tgt_q;
  assign diff_d = (TGT_W+1)'(tgt_c) - (TGT_W+1)'(c6.sep);

  always_ff @(posedge clk) begin
    if (adv) begin
      c7   <= c6;
      dv_q <= QW'(diff_d[NORM_FRAC +: DV_W]);
    end
  end

  // Stage 8: numerators for the inverse-mass shares
  logic [NUM_W-1:0] nv1_q;
  logic [NUM_W-1:0] nv2_q;
  logic [NUM_W-1:0] nx1_q;
  logic [NUM_W-1:0] nx2_q;
  ctx_t             c8;

  always_ff @(posedge clk) begin
    if (adv) begin
      c8    <= c7;
      nv1_q <= dv_q * c7.im1;
      nv2_q <= dv_q * c7.im2;
      nx1_q <= QW'(c7.pen_use) * c7.im1;
      nx2_q <= QW'(c7.pen_use) * c7.im2;
    end
  end

  // Divider stages: share by inverse mass over the total
  logic [QW-1:0] wv1;
  logic [QW-1:0] wv2;
  logic [QW-1:0] wx1;
  logic [QW-1:0] wx2;
  ctx_t          cd [QW];

  pcr_div #(.QW(QW)) u_div_v1 (
    .clk(clk), .en(adv), .num(nv1_q), .den(c8.total), .quo(wv1)
  );
  pcr_div #(.QW(QW)) u_div_v2 (
    .clk(clk), .en(adv), .num(nv2_q), .den(c8.total), .quo(wv2)
  );
  pcr_div #(.QW(QW)) u_div_x1 (
    .clk(clk), .en(adv), .num(nx1_q), .den(c8.total), .quo(wx1)
  );
  pcr_div #(.QW(QW)) u_div_x2 (
    .clk(clk), .en(adv), .num(nx2_q), .den(c8.total), .quo(wx2)
  );

  // Hold the request context alongside the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      cd[0] <= c8;
      for (int k = 1; k < QW; k++) begin
        cd[k] <= cd[k-1];
      end
    end
  end

  // Stage 9: normal components times each share
  logic signed [QW:0]          wsel [4];
  logic signed [NORM_BITS-1:0] nd   [3];
  logic signed [WP_W-1:0]      pr_d [4][3];
  logic signed [WP_W-1:0]      pr_q [4][3];
  ctx_t                        c9;

  always_comb begin
    wsel[0] = $signed({1'b0, wv1});
    wsel[1] = $signed({1'b0, wv2});
    wsel[2] = $signed({1'b0, wx1});
    wsel[3] = $signed({1'b0, wx2});
    for (int i = 0; i < 3; i++) begin
      nd[i] = $signed(cd[QW-1].n[i*NORM_BITS +: NORM_BITS]);
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        pr_d[k][i] = wsel[k] * nd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c9   <= cd[QW-1];
      pr_q <= pr_d;
    end
  end

  // Stage 10: move along the normal, saturate, select and register the result
  function automatic logic [C-1:0] sat_c(input logic signed [R_W-1:0] r);
    logic signed [R_W-1:0] s;
    s = r;
    if (r > MAX_C) s = MAX_C;
    if (r < MIN_C) s = MIN_C;
    return s[C-1:0];
  endfunction

  logic [C3-1:0]          base [4];
  logic [C3-1:0]          upd  [4];
  logic                   use_upd [4];
  logic signed [R_W-1:0]  rsum;
  logic signed [R_W-1:0]  dd;
  logic [VEC_W-1:0]       ovec [4];
  logic [M_TDATA_W-1:0]   mdata_d;

  always_comb begin
    base[0]    = c9.v1;
    base[1]    = c9.v2;
    base[2]    = c9.x1;
    base[3]    = c9.x2;
    use_upd[0] = c9.imp;
    use_upd[1] = c9.imp && c9.two;
    use_upd[2] = c9.pos;
    use_upd[3] = c9.pos && c9.two;
    rsum       = '0;
    dd         = '0;
    for (int k = 0; k < 4; k++) begin
      upd[k] = '0;
      for (int i = 0; i < 3; i++) begin
        dd = R_W'(pr_q[k][i] >>> NORM_FRAC);
        // Second particle moves against the normal
        if (k == 1 || k == 3) begin
          rsum = R_W'($signed(base[k][i*C +: C])) - dd;
        end else begin
          rsum = R_W'($signed(base[k][i*C +: C])) + dd;
        end
        upd[k][i*C +: C] = sat_c(rsum);
      end
      ovec[k]        = '0;
      ovec[k][C3-1:0] = use_upd[k] ? upd[k] : base[k];
    end
    mdata_d                   = '0;
    mdata_d[OV1_LSB +: VEC_W] = ovec[0];
    mdata_d[OV2_LSB +: VEC_W] = ovec[1];
    mdata_d[OX1_LSB +: VEC_W] = ovec[2];
    mdata_d[OX2_LSB +: VEC_W] = ovec[3];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= mdata_d;
      m_tuser <= {c9.pos, c9.imp};
    end
  end

endmodule

`default_nettype wire

// ===== bench/pcr_checker.sv =====
// Checker for the particle contact resolver: watches config writes and both
// stream channels, predicts each resolved contact and compares field by field.
// Depends on pcr_pkg for the stream layout.
module pcr_checker
  import pcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [HTS_W-1:0]     cfg_wr_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // v1, v2, a1, a2, x1, x2, normal, im1, im2, rest, pen
  input  logic                 s_tuser,   // has_second
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // new v1, new v2, new x1, new x2
  input  logic [1:0]           m_tuser,   // impulse_applied, position_corrected
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 21;

  typedef struct packed {
    logic [VEC_W-1:0] v1;
    logic [VEC_W-1:0] v2;
    logic [VEC_W-1:0] x1;
    logic [VEC_W-1:0] x2;
    logic             impulse;
    logic             corrected;
  } resolved_t;

  resolved_t   resolved_q[$];
  logic [HTS_W-1:0] hts;

  assign pending = resolved_q.size();

  function automatic longint comp(input logic [VEC_W-1:0] vec, input int i);
    logic signed [CB-1:0] c;
    c = vec[i*CB +: CB];
    return longint'(c);
  endfunction

  function automatic logic [VEC_W-1:0] sat_pack(input longint c0, input longint c1,
                                                input longint c2);
    longint c[3];
    logic [VEC_W-1:0] r;
    c[0] = c0; c[1] = c1; c[2] = c2;
    for (int i = 0; i < 3; i++) begin
      if (c[i] > 1048575) c[i] = 1048575;
      if (c[i] < -1048576) c[i] = -1048576;
      r[i*CB +: CB] = c[i][CB-1:0];
    end
    return r;
  endfunction

  // base +/- floor(n * w / 2^19) per component, saturated
  function automatic logic [VEC_W-1:0] push(input logic [VEC_W-1:0] base,
                                            input logic [VEC_W-1:0] nrm,
                                            input longint w, input bit sub);
    longint r[3];
    longint d;
    for (int i = 0; i < 3; i++) begin
      d = (comp(nrm, i) * w) >>> NORM_FRAC;
      r[i] = sub ? comp(base, i) - d : comp(base, i) + d;
    end
    return sat_pack(r[0], r[1], r[2]);
  endfunction

  function automatic resolved_t resolve_contact(input logic [S_TDATA_W-1:0] d,
                                                input logic two,
                                                input logic [HTS_W-1:0] h);
    resolved_t res;
    logic [VEC_W-1:0] v1, v2, a1, a2, x1, x2, nrm;
    logic signed [PEN_W-1:0] pen_raw;
    longint im1, im2, rest, pen, total, sep, adot, hi, lo, acc, tgt, dv;
    v1 = d[V1_LSB +: VEC_W];
    v2 = d[V2_LSB +: VEC_W];
    a1 = d[A1_LSB +: VEC_W];
    a2 = d[A2_LSB +: VEC_W];
    x1 = d[X1_LSB +: VEC_W];
    x2 = d[X2_LSB +: VEC_W];
    nrm = d[N_LSB +: VEC_W];
    im1 = longint'(d[IM1_LSB +: MASS_W]);
    im2 = two ? longint'(d[IM2_LSB +: MASS_W]) : 0;
    rest = longint'(d[REST_LSB +: REST_W]);
    pen_raw = d[PEN_LSB +: PEN_W];
    pen = longint'(pen_raw);
    total = im1 + im2;
    sep = 0;
    adot = 0;
    for (int i = 0; i < 3; i++) begin
      sep += (two ? comp(v1, i) - comp(v2, i) : comp(v1, i)) * comp(nrm, i);
      adot += (two ? comp(a1, i) - comp(a2, i) : comp(a1, i)) * comp(nrm, i);
    end
    res.v1 = sat_pack(comp(v1, 0), comp(v1, 1), comp(v1, 2));
    res.v2 = sat_pack(comp(v2, 0), comp(v2, 1), comp(v2, 2));
    res.x1 = sat_pack(comp(x1, 0), comp(x1, 1), comp(x1, 2));
    res.x2 = sat_pack(comp(x2, 0), comp(x2, 1), comp(x2, 2));
    res.impulse = 1'b0;
    res.corrected = 1'b0;
    // impulse on approaching or resting contacts
    if (sep <= 0 && total > 0) begin
      hi = longint'(h >> 12);
      lo = longint'(h & 24'hFFF);
      acc = (adot * hi + ((adot * lo) >>> 12)) >>> 12;
      tgt = (rest * (-sep + (acc < 0 ? acc : 0))) >>> REST_FRAC;
      if (tgt < 0) tgt = 0;
      dv = (tgt - sep) >>> NORM_FRAC;
      res.v1 = push(v1, nrm, dv * im1 / total, 1'b0);
      if (two) res.v2 = push(v2, nrm, dv * im2 / total, 1'b1);
      res.impulse = 1'b1;
    end
    // push out along the normal
    if (pen >= 0 && total > 0) begin
      res.x1 = push(x1, nrm, pen * im1 / total, 1'b0);
      if (two) res.x2 = push(x2, nrm, pen * im2 / total, 1'b1);
      res.corrected = 1'b1;
    end
    return res;
  endfunction

  // Track register, queue predictions, compare results
  always @(posedge clk) begin
    resolved_t want;
    if (rst) begin
      hts <= HTS_RESET;
      resolved_q.delete();
      errors <= 0;
    end else begin
      if (cfg_wr_en) hts <= cfg_wr_data;
      if (s_tvalid && s_tready) resolved_q.push_back(resolve_contact(s_tdata, s_tuser, hts));
      if (m_tvalid && m_tready) begin
        if (resolved_q.size() == 0) begin
          $error("unexpected result, m_tdata %h", m_tdata);
          errors <= errors + 1;
        end else begin
          want = resolved_q.pop_front();
          if (m_tdata[OV1_LSB +: VEC_W] !== want.v1 || m_tdata[OV2_LSB +: VEC_W] !== want.v2 ||
              m_tdata[OX1_LSB +: VEC_W] !== want.x1 || m_tdata[OX2_LSB +: VEC_W] !== want.x2 ||
              m_tuser[0] !== want.impulse || m_tuser[1] !== want.corrected)
            errors <= errors + 1;
          if (m_tdata[OV1_LSB +: VEC_W] !== want.v1)
            $error("p1_new_velocity: expected %h, got %h", want.v1, m_tdata[OV1_LSB +: VEC_W]);
          if (m_tdata[OV2_LSB +: VEC_W] !== want.v2)
            $error("p2_new_velocity: expected %h, got %h", want.v2, m_tdata[OV2_LSB +: VEC_W]);
          if (m_tdata[OX1_LSB +: VEC_W] !== want.x1)
            $error("p1_new_position: expected %h, got %h", want.x1, m_tdata[OX1_LSB +: VEC_W]);
          if (m_tdata[OX2_LSB +: VEC_W] !== want.x2)
            $error("p2_new_position: expected %h, got %h", want.x2, m_tdata[OX2_LSB +: VEC_W]);
          if (m_tuser[0] !== want.impulse)
            $error("impulse_applied: expected %0b, got %0b", want.impulse, m_tuser[0]);
          if (m_tuser[1] !== want.corrected)
            $error("position_corrected: expected %0b, got %0b", want.corrected, m_tuser[1]);
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the contact resolver bench: clock, reset, contact stimulus with bursts
// and gaps, output stalls, config phases and the verdict.
// Depends on pcr_pkg, particle_contact_resolver and pcr_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcr_pkg::*;

  localparam int LATENCY = 38;

  typedef struct {
    logic [VEC_W-1:0]  v1, v2, a1, a2, x1, x2, nrm;
    logic [MASS_W-1:0] im1, im2;
    logic [REST_W-1:0] rest;
    logic [PEN_W-1:0]  pen;
    logic              two;
  } contact_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [HTS_W-1:0]     cfg_wr_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;
  int                   errors;
  int                   pending;
  int                   stall_mode = 0;

  always #2 clk = ~clk;

  particle_contact_resolver dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  pcr_checker chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  // Stall the output on a pattern that changes mode at random
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 9) < 7);
      2: m_tready <= ($urandom_range(0, 9) < 3);
      default: m_tready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  function automatic logic [20:0] rand_comp(input bit tame);
    case ($urandom_range(0, tame ? 1 : 3))
      0: return 21'($signed($urandom_range(0, 4095)) - 2048);
      1: return 21'($signed($urandom_range(0, 131071)) - 65536);
      2: return 21'($urandom());
      default: return $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] rand_vec(input bit tame);
    return {rand_comp(tame), rand_comp(tame), rand_comp(tame)};
  endfunction

  // Unit along one axis, a diagonal, or arbitrary bits
  function automatic logic [VEC_W-1:0] rand_normal(input bit tame);
    logic [VEC_W-1:0] n;
    int ax;
    n = '0;
    if (!tame && $urandom_range(0, 1)) return VEC_W'({$urandom(), $urandom()});
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 3; i++)
        n[i*21 +: 21] = $urandom_range(0, 1) ? 21'sd302700 : -21'sd302700;
    end else begin
      ax = $urandom_range(0, 2);
      n[ax*21 +: 21] = $urandom_range(0, 1) ? 21'sd524288 : -21'sd524288;
    end
    return n;
  endfunction

  function automatic contact_t rand_contact(input bit tame);
    contact_t c;
    c.v1 = rand_vec(tame); c.v2 = rand_vec(tame);
    c.a1 = rand_vec(tame); c.a2 = rand_vec(tame);
    c.x1 = rand_vec(tame); c.x2 = rand_vec(tame);
    c.nrm = rand_normal(tame);
    c.im1 = ($urandom_range(0, 9) == 0) ? '0 :
            MASS_W'(tame ? $urandom_range(1, 262144) : $urandom());
    c.im2 = ($urandom_range(0, 9) == 0) ? '0 :
            MASS_W'(tame ? $urandom_range(1, 262144) : $urandom());
    c.rest = REST_W'(tame ? $urandom_range(0, 65536) : $urandom());
    c.pen = tame ? 21'($signed($urandom_range(0, 2047)) - 512) : PEN_W'($urandom());
    c.two = $urandom_range(0, 3) != 0;
    return c;
  endfunction

  task automatic send_contact(input contact_t c);
    s_tvalid <= 1'b1;
    s_tuser <= c.two;
    s_tdata <= {1'b0, c.pen, c.rest, c.im2, c.im1, c.nrm, c.x2, c.x1, c.a2, c.a1, c.v2, c.v1};
    do @(posedge clk); while (!s_tready);
  endtask

  // Send in bursts with random gaps; some stretches run back to back
  task automatic send_random(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && count > 0; i++, count--)
        send_contact(rand_contact($urandom_range(0, 9) < 7));
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  // Hold until every result is back, let the pipeline drain, then write config
  task automatic drain_and_write(input logic [HTS_W-1:0] value);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    contact_t c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all zero, world contact
    c = rand_contact(1'b1);
    c.v1 = '0; c.v2 = '0; c.a1 = '0; c.a2 = '0; c.x1 = '0; c.x2 = '0; c.nrm = '0;
    c.im1 = '0; c.im2 = '0; c.rest = '0; c.pen = '0; c.two = 1'b0;
    send_contact(c);
    // Positive extremes, restitution of one
    c.v1 = {3{21'h0FFFFF}}; c.v2 = c.v1; c.a1 = c.v1; c.a2 = c.v1; c.x1 = c.v1; c.x2 = c.v1;
    c.nrm = c.v1; c.im1 = '1; c.im2 = '1; c.rest = 17'd65536; c.pen = 21'h0FFFFF; c.two = 1'b1;
    send_contact(c);
    // Negative extremes, restitution above one
    c.v1 = {3{21'h100000}}; c.v2 = '0; c.a1 = c.v1; c.a2 = '0; c.x1 = c.v1; c.x2 = c.v1;
    c.nrm = {3{21'h0FFFFF}}; c.rest = '1; c.pen = 21'h100000;
    send_contact(c);
    // Approaching along x, then separating, then zero mass variants
    c = rand_contact(1'b1);
    c.nrm = 63'd524288; c.v1 = 63'(21'h1FFF00); c.v2 = 63'd300; c.two = 1'b1;
    c.im1 = 24'd65536; c.im2 = 24'd65536; c.rest = 17'd32768; c.pen = 21'd50;
    send_contact(c);
    c.v1 = 63'd300; c.v2 = 63'(21'h1FFF00);
    send_contact(c);
    c.v1 = 63'(21'h1FFF00); c.im1 = '0; c.im2 = '0;
    send_contact(c);
    c.im2 = 24'd12345; c.two = 1'b0;
    send_contact(c);
    // Zero penetration, full restitution, strong and positive acceleration terms
    c.im1 = 24'd65536; c.two = 1'b1; c.pen = '0; c.rest = 17'd65536;
    send_contact(c);
    c.a1 = 63'(21'h100000); c.a2 = 63'd1048575; c.pen = 21'd7;
    send_contact(c);
    c.a1 = 63'd1048575; c.a2 = 63'(21'h100000);
    send_contact(c);
    // World contact with arbitrary second-particle fields
    c = rand_contact(1'b0);
    c.two = 1'b0;
    send_contact(c);
    for (int i = 0; i < 8; i++) send_contact(rand_contact(i[0]));
    s_tvalid <= 1'b0;

    send_random(225);
    drain_and_write('0);
    send_random(225);
    drain_and_write('1);
    send_random(225);
    drain_and_write(HTS_W'($urandom()));
    send_random(225);

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
